@@ sv/shq_pkg.sv @@
// shq_pkg: types, constants and the angle step table for the segment heading block.
// Used by shq_vec_cell, shq_rot_cell and segment_heading_quaternion_top.
`default_nettype none
package shq_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 16;

    localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int VW  = 38;
    localparam int ZW  = ANGLE_BITS + 2;
    localparam int RW  = 34;
    localparam int AS  = 32 - ANGLE_BITS;
    localparam int US  = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
    localparam int UL  = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam int LAT = 3 * NST + 6;

    localparam logic signed [31:0] GAIN_Q30     = 32'sd1768195361;
    localparam logic signed [RW-1:0] INV_GAIN   = RW'(652032874);
    localparam logic signed [ZW-1:0] PI_U       = ZW'(1) <<< (ANGLE_BITS - 1);
    localparam logic signed [ZW-1:0] HALF_PI_U  = ZW'(1) <<< (ANGLE_BITS - 2);

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] z;
    } rot_t;

    typedef struct packed {
        logic                 degen;
        logic                 vert;
        logic                 dz_neg;
        logic signed [32:0]   dz;
        logic signed [ZW-1:0] yaw;
    } side_t;

    typedef struct packed {
        logic               degen;
        logic signed [15:0] heading;
        logic signed [15:0] elevation;
    } outside_t;

    function automatic logic signed [ZW-1:0] step_angle(input logic [4:0] i);
        logic [32:0] t;
        t = ({1'b0, ATAN_TAB[i]} + (33'd1 << (AS - 1))) >> AS;
        return ZW'(t);
    endfunction

endpackage
`default_nettype wire

@@ sv/shq_vec_cell.sv @@
// shq_vec_cell: one vectoring CORDIC cell, registered.
// Depends on shq_pkg (vec_t, step_angle).
`default_nettype none
module shq_vec_cell
    import shq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire logic [4:0] stage,
    input  wire vec_t       din,
    output vec_t            dout
);

    vec_t                 cell_next;
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;

    always_comb
    begin
        xs = din.x >>> stage;
        ys = din.y >>> stage;
        if (!din.y[VW-1])
        begin
            cell_next.x = din.x + ys;
            cell_next.y = din.y - xs;
            cell_next.z = din.z + step_angle(stage);
        end
        else
        begin
            cell_next.x = din.x - ys;
            cell_next.y = din.y + xs;
            cell_next.z = din.z - step_angle(stage);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout <= cell_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/shq_rot_cell.sv @@
// shq_rot_cell: one rotation CORDIC cell, registered, angles with pi = 2^31.
// Depends on shq_pkg (rot_t, ATAN_TAB).
`default_nettype none
module shq_rot_cell
    import shq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       en,
    input  wire logic [4:0] stage,
    input  wire rot_t       din,
    output rot_t            dout
);

    rot_t                 cell_next;
    logic signed [RW-1:0] xs;
    logic signed [RW-1:0] ys;
    logic signed [RW-1:0] at;

    always_comb
    begin
        xs = din.x >>> stage;
        ys = din.y >>> stage;
        at = RW'(ATAN_TAB[stage]);
        if (!din.z[RW-1])
        begin
            cell_next.x = din.x - ys;
            cell_next.y = din.y + xs;
            cell_next.z = din.z - at;
        end
        else
        begin
            cell_next.x = din.x + ys;
            cell_next.y = din.y - xs;
            cell_next.z = din.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout <= cell_next;
        end
    end

endmodule
`default_nettype wire

@@ sv/segment_heading_quaternion_top.sv @@
// segment_heading_quaternion_top: segment direction to yaw/pitch and unit quaternion.
// Depends on shq_pkg, shq_vec_cell, shq_rot_cell.
//
// Usage: present a segment request (start and end points, Q16.16) on
// in_valid/in_ready; one result per request comes out on out_valid/out_ready
// with the quaternion in Q1.15, heading and elevation in binary angle units,
// and the degenerate flag for a zero-length segment.
// The yaw and pitch vectoring cell rows and the rotation cell rows lie in series
// on the path from request to result.
// Throughput: one request per cycle while the receiver does not stall; the whole row of cells advances together.
// When the receiver stalls with a result waiting, every stage holds and
// in_ready drops; requests still in flight keep their place.
// Reset clears the valid bits of all stages; data registers are not reset.
`default_nettype none
module segment_heading_quaternion_top
    import shq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] start_x,
    input  wire logic signed [31:0] start_y,
    input  wire logic signed [31:0] start_z,
    input  wire logic signed [31:0] end_x,
    input  wire logic signed [31:0] end_y,
    input  wire logic signed [31:0] end_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [15:0]      quat_x,
    output logic signed [15:0]      quat_y,
    output logic signed [15:0]      quat_z,
    output logic signed [15:0]      quat_w,
    output logic signed [15:0]      heading,
    output logic signed [15:0]      elevation,
    output logic                    degenerate
);

    logic            adv;
    logic [LAT-1:0]  vld_reg;

    vec_t     yv [0:NST];
    vec_t     pv [0:NST];
    rot_t     hv [0:NST];
    rot_t     ev [0:NST];
    side_t    ys_reg [0:NST];
    side_t    ps_reg [0:NST];
    outside_t os_reg [0:NST];

    vec_t     yin_reg;
    vec_t     yin_next;
    side_t    sa_next;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;

    logic signed [64:0]   prod_reg;
    logic signed [VW-1:0] rk_reg;
    side_t                sb_reg;
    side_t                sb_next;
    vec_t                 pin_reg;
    logic signed [64:0]   zk_wide;

    rot_t                 hin_reg;
    rot_t                 ein_reg;
    rot_t                 hin_next;
    rot_t                 ein_next;
    outside_t             od_next;
    logic signed [ZW-1:0] pit;
    logic signed [39:0]   yaw_u;
    logic signed [39:0]   pit_u;
    logic signed [39:0]   el_w;
    logic signed [15:0]   hd;
    logic signed [15:0]   el;

    localparam logic signed [39:0] URND = (40'sd1 <<< US) >>> 1;

    logic signed [2*RW-1:0] px_reg;
    logic signed [2*RW-1:0] py_reg;
    logic signed [2*RW-1:0] pz_reg;
    logic signed [2*RW-1:0] pw_reg;
    outside_t               oe_reg;

    function automatic logic signed [15:0] q15(input logic signed [2*RW-1:0] p);
        logic signed [2*RW-1:0] r;
        r = (p + (2*RW)'(64'sd1 <<< 44)) >>> 45;
        if (r > (2*RW)'(32767))
        begin
            return 16'sd32767;
        end
        else if (r < -(2*RW)'(32768))
        begin
            return -16'sd32768;
        end
        return r[15:0];
    endfunction

    function automatic logic signed [39:0] to_units16(input logic signed [ZW-1:0] a);
        logic signed [39:0] t;
        t = 40'(a);
        if (US > 0)
        begin
            return (t + URND) >>> US;
        end
        return t <<< UL;
    endfunction

    assign adv      = !vld_reg[LAT-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // input stage: difference vector and yaw start point
    always_comb
    begin
        dx = 33'(end_x) - 33'(start_x);
        dy = 33'(end_y) - 33'(start_y);
        dz = 33'(end_z) - 33'(start_z);
        if (dx[32])
        begin
            yin_next.x = -VW'(dx);
            yin_next.y = -VW'(dy);
            yin_next.z = dy[32] ? -PI_U : PI_U;
        end
        else
        begin
            yin_next.x = VW'(dx);
            yin_next.y = VW'(dy);
            yin_next.z = '0;
        end
        sa_next.vert   = (dx == '0) && (dy == '0);
        sa_next.degen  = sa_next.vert && (dz == '0);
        sa_next.dz_neg = dz[32];
        sa_next.dz     = dz;
        sa_next.yaw    = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yin_reg   <= yin_next;
            ys_reg[0] <= sa_next;
            for (int k = 1; k <= NST; k++)
            begin
                ys_reg[k] <= ys_reg[k-1];
            end
        end
    end

    assign yv[0] = yin_reg;
    assign pv[0] = pin_reg;
    assign hv[0] = hin_reg;
    assign ev[0] = ein_reg;

    for (genvar i = 0; i < NST; i++)
    begin : g_cells
        shq_vec_cell u_yaw (
            .clk   (clk),
            .en    (adv),
            .stage (5'(i)),
            .din   (yv[i]),
            .dout  (yv[i+1])
        );
        shq_vec_cell u_pitch (
            .clk   (clk),
            .en    (adv),
            .stage (5'(i)),
            .din   (pv[i]),
            .dout  (pv[i+1])
        );
        shq_rot_cell u_hrot (
            .clk   (clk),
            .en    (adv),
            .stage (5'(i)),
            .din   (hv[i]),
            .dout  (hv[i+1])
        );
        shq_rot_cell u_erot (
            .clk   (clk),
            .en    (adv),
            .stage (5'(i)),
            .din   (ev[i]),
            .dout  (ev[i+1])
        );
    end

    // gain-scale dz, then start the pitch row
    always_comb
    begin
        sb_next     = ys_reg[NST];
        sb_next.yaw = ys_reg[NST].vert ? '0 : yv[NST].z;
        zk_wide     = (prod_reg + 65'sd536870912) >>> 30;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= ys_reg[NST].dz * 65'(GAIN_Q30);
            rk_reg    <= yv[NST].x;
            sb_reg    <= sb_next;
            pin_reg.x <= rk_reg;
            pin_reg.y <= VW'(zk_wide);
            pin_reg.z <= '0;
            ps_reg[0] <= sb_reg;
            for (int k = 1; k <= NST; k++)
            begin
                ps_reg[k] <= ps_reg[k-1];
            end
        end
    end

    // angles to 16-bit units, then start the rotation rows on half angles
    always_comb
    begin
        if (ps_reg[NST].vert)
        begin
            pit = ps_reg[NST].dz_neg ? -HALF_PI_U : HALF_PI_U;
        end
        else
        begin
            pit = pv[NST].z;
        end
        if (pit > HALF_PI_U)
        begin
            pit = HALF_PI_U;
        end
        if (pit < -HALF_PI_U)
        begin
            pit = -HALF_PI_U;
        end
        yaw_u = to_units16(ps_reg[NST].yaw);
        pit_u = to_units16(pit);
        hd    = yaw_u[15:0];
        el_w  = -pit_u;
        if (el_w > 40'sd16384)
        begin
            el_w = 40'sd16384;
        end
        if (el_w < -40'sd16384)
        begin
            el_w = -40'sd16384;
        end
        el = el_w[15:0];
        hin_next.x = INV_GAIN;
        hin_next.y = '0;
        hin_next.z = {{(RW-31){hd[15]}}, hd, 15'b0};
        ein_next.x = INV_GAIN;
        ein_next.y = '0;
        ein_next.z = {{(RW-31){el[15]}}, el, 15'b0};
        od_next.degen     = ps_reg[NST].degen;
        od_next.heading   = hd;
        od_next.elevation = el;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hin_reg   <= hin_next;
            ein_reg   <= ein_next;
            os_reg[0] <= od_next;
            for (int k = 1; k <= NST; k++)
            begin
                os_reg[k] <= os_reg[k-1];
            end
            px_reg    <= -((2*RW)'(ev[NST].y) * (2*RW)'(hv[NST].y));
            py_reg    <= (2*RW)'(ev[NST].y) * (2*RW)'(hv[NST].x);
            pz_reg    <= (2*RW)'(ev[NST].x) * (2*RW)'(hv[NST].y);
            pw_reg    <= (2*RW)'(ev[NST].x) * (2*RW)'(hv[NST].x);
            oe_reg    <= os_reg[NST];
            if (oe_reg.degen)
            begin
                quat_x    <= '0;
                quat_y    <= '0;
                quat_z    <= '0;
                quat_w    <= 16'sd32767;
                heading   <= '0;
                elevation <= '0;
            end
            else
            begin
                quat_x    <= q15(px_reg);
                quat_y    <= q15(py_reg);
                quat_z    <= q15(pz_reg);
                quat_w    <= q15(pw_reg);
                heading   <= oe_reg.heading;
                elevation <= oe_reg.elevation;
            end
            degenerate <= oe_reg.degen;
        end
    end

    assign out_valid = vld_reg[LAT-1];

    a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> quat_x == 16'sd0 && quat_w == 16'sd32767
            && heading == 16'sd0)
        else $error("degenerate result is not the identity");

    a_elev_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> elevation <= 16'sd16384 && elevation >= -16'sd16384)
        else $error("elevation out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> in_ready == 1'b0)
        else $error("request taken while result stalled");

endmodule
`default_nettype wire
